### src/cbref_pkg.sv
// Shared types, widths, register indexes and reset values for the color band
// row edge finder. No dependencies.
package cbref_pkg;

    localparam int COORD_BITS = 12;
    localparam int FIELD_BITS = 12;
    localparam int WIDTH_BITS = 13;
    localparam int ANGLE_BITS = 9;
    localparam int CHAN_BITS  = 8;
    localparam int CFG_BITS   = 13;
    localparam int IDX_BITS   = 3;
    localparam int EXT_BITS   = (COORD_BITS + 1 > WIDTH_BITS) ? COORD_BITS + 1 : WIDTH_BITS;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [FIELD_BITS-1:0] field_t;
    typedef logic [EXT_BITS-1:0]   ext_t;
    typedef logic [CHAN_BITS-1:0]  chan_t;
    typedef logic [ANGLE_BITS-1:0] angle_t;

    localparam logic [IDX_BITS-1:0] REG_CENTER_COL  = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_ROW_STEP    = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_IMAGE_WIDTH = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_HUE_LOW     = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_HUE_HIGH    = 3'd4;
    localparam logic [IDX_BITS-1:0] REG_SAT_MIN     = 3'd5;
    localparam logic [IDX_BITS-1:0] REG_VAL_MIN     = 3'd6;
    localparam logic [IDX_BITS-1:0] REG_FRAME_ANGLE = 3'd7;

    localparam field_t                RST_CENTER_COL  = 12'd417;
    localparam field_t                RST_ROW_STEP    = 12'd46;
    localparam logic [WIDTH_BITS-1:0] RST_IMAGE_WIDTH = 13'd800;
    localparam chan_t                 RST_HUE_LOW     = 8'd100;
    localparam chan_t                 RST_HUE_HIGH    = 8'd135;
    localparam chan_t                 RST_SAT_MIN     = 8'd125;
    localparam chan_t                 RST_VAL_MIN     = 8'd100;
    localparam angle_t                RST_FRAME_ANGLE = 9'd0;

    localparam ext_t WIDTH_CAP = ext_t'(1) << COORD_BITS;

endpackage

### src/color_band_row_edge_finder.sv
// Top level of the color band row edge finder: pixel counters, band match,
// per-row result word with output register and skid word. Uses cbref_pkg.
//
// Usage: HSV pixels enter in raster order on the input channel (in_valid,
// in_stall, hue, saturation, brightness, frame_start); frame_start on a pixel
// restarts the column and row counters at zero for that pixel. Every
// row_step-th row, starting at row 0, is searched below center_col and the
// row width for the first pixel inside the color band. At most one result
// word per examined row leaves on the output channel (out_valid, out_stall,
// offset, row, hit, angle).
// A result word is registered in the output register when the pixel that
// causes it is accepted; while the receiver stalls, the pending word holds
// there and one more word is caught in a skid register, and only while that
// skid word is occupied is in_stall high. While in_stall is low, one pixel is
// accepted per cycle, in the single registered pass of compares and counter
// updates. Reset loads the register defaults, clears the counters and empties
// both result registers. The user must write configuration through cfg_we,
// cfg_index and cfg_data only while the block is idle, which is not enforced.
module color_band_row_edge_finder
    import cbref_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [IDX_BITS-1:0]   cfg_index,
    input  logic [CFG_BITS-1:0]   cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [CHAN_BITS-1:0]  hue,
    input  logic [CHAN_BITS-1:0]  saturation,
    input  logic [CHAN_BITS-1:0]  brightness,
    input  logic                  frame_start,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [FIELD_BITS-1:0] offset,
    output logic [FIELD_BITS-1:0] row,
    output logic                  hit,
    output logic [ANGLE_BITS-1:0] angle
);

    field_t                center_col_reg;
    field_t                row_step_reg;
    logic [WIDTH_BITS-1:0] image_width_reg;
    chan_t                 hue_low_reg;
    chan_t                 hue_high_reg;
    chan_t                 sat_min_reg;
    chan_t                 val_min_reg;
    angle_t                frame_angle_reg;

    coord_t col_reg, col_next;
    coord_t row_cnt_reg, row_cnt_next;
    field_t until_reg, until_next;
    logic   done_reg, done_next;

    logic   out_valid_reg, out_valid_next;
    field_t offset_reg, offset_next;
    field_t row_reg, row_next;
    logic   hit_reg, hit_next;
    angle_t angle_reg, angle_next;

    logic   skid_valid_reg, skid_valid_next;
    field_t skid_offset_reg, skid_offset_next;
    field_t skid_row_reg, skid_row_next;
    logic   skid_hit_reg, skid_hit_next;
    angle_t skid_angle_reg, skid_angle_next;

    logic   in_fire;
    logic   out_fire;
    coord_t cur_col;
    coord_t cur_row;
    field_t cur_until;
    logic   cur_done;
    ext_t   width;
    ext_t   limit;
    ext_t   col_ext;
    ext_t   col_inc_ext;
    coord_t col_inc;
    field_t step;
    logic   band_match;
    logic   in_range;
    logic   res_valid;
    logic   res_hit;
    field_t res_offset;
    field_t res_row;
    logic   row_wrap;

    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid_reg && !out_stall;
    assign in_stall = skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_col_reg  <= RST_CENTER_COL;
            row_step_reg    <= RST_ROW_STEP;
            image_width_reg <= RST_IMAGE_WIDTH;
            hue_low_reg     <= RST_HUE_LOW;
            hue_high_reg    <= RST_HUE_HIGH;
            sat_min_reg     <= RST_SAT_MIN;
            val_min_reg     <= RST_VAL_MIN;
            frame_angle_reg <= RST_FRAME_ANGLE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CENTER_COL:  center_col_reg  <= cfg_data[FIELD_BITS-1:0];
                REG_ROW_STEP:    row_step_reg    <= cfg_data[FIELD_BITS-1:0];
                REG_IMAGE_WIDTH: image_width_reg <= cfg_data[WIDTH_BITS-1:0];
                REG_HUE_LOW:     hue_low_reg     <= cfg_data[CHAN_BITS-1:0];
                REG_HUE_HIGH:    hue_high_reg    <= cfg_data[CHAN_BITS-1:0];
                REG_SAT_MIN:     sat_min_reg     <= cfg_data[CHAN_BITS-1:0];
                REG_VAL_MIN:     val_min_reg     <= cfg_data[CHAN_BITS-1:0];
                REG_FRAME_ANGLE: frame_angle_reg <= cfg_data[ANGLE_BITS-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        cur_col   = frame_start ? '0 : col_reg;
        cur_row   = frame_start ? '0 : row_cnt_reg;
        cur_until = frame_start ? '0 : until_reg;
        cur_done  = frame_start ? 1'b0 : done_reg;

        if (image_width_reg == '0)
        begin
            width = ext_t'(1);
        end
        else if (ext_t'(image_width_reg) > WIDTH_CAP)
        begin
            width = WIDTH_CAP;
        end
        else
        begin
            width = ext_t'(image_width_reg);
        end

        limit = (ext_t'(center_col_reg) < width) ? ext_t'(center_col_reg) : width;

        col_ext     = ext_t'(cur_col);
        col_inc     = cur_col + coord_t'(1);
        col_inc_ext = ext_t'(col_inc);
        band_match  = (hue > hue_low_reg) && (hue < hue_high_reg)
                      && (saturation > sat_min_reg) && (brightness > val_min_reg);
        in_range    = col_ext < limit;

        res_valid = 1'b0;
        res_hit   = 1'b0;
        if ((cur_until == '0) && !cur_done)
        begin
            if (in_range)
            begin
                res_hit   = band_match;
                res_valid = band_match || ((col_ext + ext_t'(1)) == limit);
            end
            else if ((limit == '0) && (cur_col == '0))
            begin
                res_valid = 1'b1;
            end
        end
        res_offset = res_hit ? (center_col_reg - field_t'(col_ext)) : '0;
        res_row    = field_t'(ext_t'(cur_row));

        step     = (row_step_reg == '0) ? field_t'(1) : row_step_reg;
        row_wrap = (col_inc_ext >= width) || (col_inc == '0);

        if (row_wrap)
        begin
            col_next     = '0;
            row_cnt_next = cur_row + coord_t'(1);
            done_next    = 1'b0;
            until_next   = (cur_until == '0) ? (step - field_t'(1))
                                             : (cur_until - field_t'(1));
        end
        else
        begin
            col_next     = col_inc;
            row_cnt_next = cur_row;
            done_next    = cur_done || res_valid;
            until_next   = cur_until;
        end
    end

    always_comb
    begin
        out_valid_next   = out_valid_reg;
        offset_next      = offset_reg;
        row_next         = row_reg;
        hit_next         = hit_reg;
        angle_next       = angle_reg;
        skid_valid_next  = skid_valid_reg;
        skid_offset_next = skid_offset_reg;
        skid_row_next    = skid_row_reg;
        skid_hit_next    = skid_hit_reg;
        skid_angle_next  = skid_angle_reg;

        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                offset_next     = skid_offset_reg;
                row_next        = skid_row_reg;
                hit_next        = skid_hit_reg;
                angle_next      = skid_angle_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (in_fire && res_valid)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_valid_next = 1'b1;
                offset_next    = res_offset;
                row_next       = res_row;
                hit_next       = res_hit;
                angle_next     = frame_angle_reg;
            end
            else
            begin
                skid_valid_next  = 1'b1;
                skid_offset_next = res_offset;
                skid_row_next    = res_row;
                skid_hit_next    = res_hit;
                skid_angle_next  = frame_angle_reg;
            end
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_cnt_reg    <= '0;
            until_reg      <= '0;
            done_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                col_reg     <= col_next;
                row_cnt_reg <= row_cnt_next;
                until_reg   <= until_next;
                done_reg    <= done_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        offset_reg      <= offset_next;
        row_reg         <= row_next;
        hit_reg         <= hit_next;
        angle_reg       <= angle_next;
        skid_offset_reg <= skid_offset_next;
        skid_row_reg    <= skid_row_next;
        skid_hit_reg    <= skid_hit_next;
        skid_angle_reg  <= skid_angle_next;
    end

    assign out_valid = out_valid_reg;
    assign offset    = offset_reg;
    assign row       = row_reg;
    assign hit       = hit_reg;
    assign angle     = angle_reg;

    // The skid word is only ever occupied behind a pending output word.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held without an output word");

    // A word enters the skid register only when the output word was stalled.
    a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && out_stall))
        else $error("skid word filled while output was free");

    // A word without a hit always carries a zero offset.
    a_nohit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !hit_reg) |-> (offset_reg == '0))
        else $error("no-hit word with nonzero offset");

endmodule
